// ===== rtl/lzsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants of the LZ77 stream decompressor: window size,
// parser phases, sequencer states and the flag-bit step record.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  // History window and derived widths
  localparam int WindowBytes    = 8192;
  localparam int AddrW          = $clog2(WindowBytes);
  localparam int DistW          = 14;
  localparam int ExtW           = AddrW + DistW;
  localparam int BytesPerResult = 4;
  localparam int CntW           = $clog2(BytesPerResult + 1);
  localparam int LaneW          = $clog2(BytesPerResult);
  localparam int RemW           = 9;

  // Format constants
  localparam logic [DistW-1:0] ShortReach = 14'h0100;
  localparam logic [DistW-1:0] LongReach  = 14'h2000;
  localparam logic [4:0]       WordBits   = 5'h10;

  // Parser phases
  typedef enum logic [3:0] {
    PH_BIT1       = 4'd0,
    PH_WORD_LO    = 4'd1,
    PH_WORD_HI    = 4'd2,
    PH_BIT2       = 4'd3,
    PH_LEN_A      = 4'd4,
    PH_LEN_B      = 4'd5,
    PH_LIT        = 4'd6,
    PH_SHORT_DIST = 4'd7,
    PH_LONG_LO    = 4'd8,
    PH_LONG_HI    = 4'd9,
    PH_EXT_LEN    = 4'd10
  } phase_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_RD,
    ST_WR,
    ST_PUSH
  } state_e;

  // Parser state after one flag-bit step
  typedef struct packed {
    phase_e      phase;
    phase_e      resume;
    logic [15:0] word;
    logic [4:0]  bits_left;
    logic [1:0]  length_bits;
    logic        done;
  } flag_step_t;

endpackage

// ===== rtl/lzsd_ram.sv =====
// ----------------------------------------------------------------------------
// lzsd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lzsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lzsd_flag_unit.sv =====
// ----------------------------------------------------------------------------
// lzsd_flag_unit
// One step of the flag-bit parser: use the next flag bit, pick the next
// phase, and park the phase when the flag word runs dry.
// ----------------------------------------------------------------------------
module lzsd_flag_unit (
  input  lzsd_pkg::phase_e     phase_i,
  input  lzsd_pkg::phase_e     resume_i,
  input  logic [15:0]          word_i,
  input  logic [4:0]           bits_left_i,
  input  logic [1:0]           length_bits_i,
  output lzsd_pkg::flag_step_t step_o
);

  logic             flag_bit;
  logic [4:0]       bits_dec;
  lzsd_pkg::phase_e next_phase;
  logic [1:0]       lb_next;
  logic             is_bit_phase;

  assign flag_bit = word_i[0];
  assign bits_dec = bits_left_i - 5'd1;
  assign is_bit_phase = phase_i inside {lzsd_pkg::PH_BIT1, lzsd_pkg::PH_BIT2,
                                        lzsd_pkg::PH_LEN_A, lzsd_pkg::PH_LEN_B};

  // Decode the phase that follows this bit
  always_comb begin
    lb_next = length_bits_i;
    case (phase_i)
      lzsd_pkg::PH_BIT1: begin
        next_phase = flag_bit ? lzsd_pkg::PH_LIT : lzsd_pkg::PH_BIT2;
      end
      lzsd_pkg::PH_BIT2: begin
        next_phase = flag_bit ? lzsd_pkg::PH_LONG_LO : lzsd_pkg::PH_LEN_A;
      end
      lzsd_pkg::PH_LEN_A: begin
        lb_next    = {flag_bit, 1'b0};
        next_phase = lzsd_pkg::PH_LEN_B;
      end
      default: begin
        lb_next    = {length_bits_i[1], flag_bit};
        next_phase = lzsd_pkg::PH_SHORT_DIST;
      end
    endcase
  end

  // Assemble the stepped state
  always_comb begin
    step_o.phase       = phase_i;
    step_o.resume      = resume_i;
    step_o.word        = word_i;
    step_o.bits_left   = bits_left_i;
    step_o.length_bits = length_bits_i;
    step_o.done        = 1'b1;
    if (is_bit_phase) begin
      if (bits_left_i == 5'd0) begin
        // Word is empty: fetch a fresh one, then resume here
        step_o.resume = phase_i;
        step_o.phase  = lzsd_pkg::PH_WORD_LO;
      end else begin
        step_o.word        = {1'b0, word_i[15:1]};
        step_o.bits_left   = bits_dec;
        step_o.length_bits = lb_next;
        if (bits_dec == 5'd0) begin
          step_o.resume = next_phase;
          step_o.phase  = lzsd_pkg::PH_WORD_LO;
        end else begin
          step_o.phase = next_phase;
          step_o.done  = 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/lzexe_stream_decompressor.sv =====
// Timing: a literal is staged in the accumulator and moved to the output
//   register in the push state; each copied byte passes a RAM read state and a
//   write-back state, and each result of up to 4 bytes a push state that waits
//   for a free output register. Input bytes are taken only in the idle state.
// Reset: asynchronous, active low; clears the parser and write position,
//   leaves the history window unwritten and needs no clearing pass.
// ----------------------------------------------------------------------------
// lzexe_stream_decompressor
// LZ77 decompressor with interleaved 16-bit flag words and an 8 KiB window;
// a small sequencer drives the flag unit, the copy address adder and the RAM.
// ----------------------------------------------------------------------------
module lzexe_stream_decompressor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte0_o,
  output logic [7:0] out_byte1_o,
  output logic [7:0] out_byte2_o,
  output logic [7:0] out_byte3_o,
  output logic [2:0] byte_count_o,
  output logic       last_of_run_o,
  output logic       stream_end_o
);

  localparam int AW = lzsd_pkg::AddrW;
  localparam int DW = lzsd_pkg::DistW;
  localparam int NB = lzsd_pkg::BytesPerResult;

  lzsd_pkg::state_e state_q, state_d;
  lzsd_pkg::phase_e phase_q, phase_d;
  lzsd_pkg::phase_e resume_q, resume_d;
  logic [15:0]                 word_q, word_d;
  logic [4:0]                  bits_q, bits_d;
  logic [7:0]                  held_q, held_d;
  logic [1:0]                  lenb_q, lenb_d;
  logic [DW-1:0]               dist_q, dist_d;
  logic [AW-1:0]               wp_q, wp_d;
  logic [lzsd_pkg::RemW-1:0]   rem_q, rem_d;
  logic [lzsd_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        end_q, end_d;
  logic [7:0]                  acc_q [NB];
  logic [7:0]                  acc_d [NB];
  logic                        ovalid_q, ovalid_d;
  logic [7:0]                  obyte_q [NB];
  logic [7:0]                  obyte_d [NB];
  logic [2:0]                  ocount_q, ocount_d;
  logic                        olast_q, olast_d;
  logic                        oend_q, oend_d;

  logic                 in_fire;
  logic                 out_free;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [7:0]           ram_rdata;
  logic [lzsd_pkg::ExtW-1:0] src_ext;
  logic [AW-1:0]        src_addr;
  lzsd_pkg::flag_step_t fstep;

  assign in_ready_o = (state_q == lzsd_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !ovalid_q || out_ready_i;

  // Copy source address: write position minus distance, modulo the window
  assign src_ext  = {{DW{1'b0}}, wp_q} - {{AW{1'b0}}, dist_q};
  assign src_addr = src_ext[AW-1:0];

  lzsd_flag_unit u_flag (
    .phase_i       (phase_q),
    .resume_i      (resume_q),
    .word_i        (word_q),
    .bits_left_i   (bits_q),
    .length_bits_i (lenb_q),
    .step_o        (fstep)
  );

  lzsd_ram #(
    .Width (8),
    .Depth (lzsd_pkg::WindowBytes)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (src_addr),
    .rdata_o (ram_rdata)
  );

  // Next state of the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      lzsd_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (phase_q)
            lzsd_pkg::PH_WORD_LO,
            lzsd_pkg::PH_LONG_LO:    state_d = lzsd_pkg::ST_IDLE;
            lzsd_pkg::PH_WORD_HI:    state_d = lzsd_pkg::ST_ADV;
            lzsd_pkg::PH_LIT:        state_d = lzsd_pkg::ST_PUSH;
            lzsd_pkg::PH_SHORT_DIST: state_d = lzsd_pkg::ST_RD;
            lzsd_pkg::PH_LONG_HI: begin
              state_d = (in_byte_i[2:0] != 3'd0) ? lzsd_pkg::ST_RD : lzsd_pkg::ST_IDLE;
            end
            lzsd_pkg::PH_EXT_LEN: begin
              if (in_byte_i == 8'd0) begin
                state_d = lzsd_pkg::ST_PUSH;
              end else if (in_byte_i == 8'd1) begin
                state_d = lzsd_pkg::ST_ADV;
              end else begin
                state_d = lzsd_pkg::ST_RD;
              end
            end
            default: state_d = lzsd_pkg::ST_ADV;
          endcase
        end
      end
      lzsd_pkg::ST_ADV: begin
        if (fstep.done) begin
          state_d = lzsd_pkg::ST_IDLE;
        end
      end
      lzsd_pkg::ST_RD: state_d = lzsd_pkg::ST_WR;
      lzsd_pkg::ST_WR: begin
        if ((rem_q == lzsd_pkg::RemW'(1)) || (cnt_q == lzsd_pkg::CntW'(NB - 1))) begin
          state_d = lzsd_pkg::ST_PUSH;
        end else begin
          state_d = lzsd_pkg::ST_RD;
        end
      end
      lzsd_pkg::ST_PUSH: begin
        if (out_free) begin
          state_d = (rem_q != '0) ? lzsd_pkg::ST_RD : lzsd_pkg::ST_ADV;
        end
      end
      default: state_d = lzsd_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM controls and output register
  always_comb begin
    phase_d   = phase_q;
    resume_d  = resume_q;
    word_d    = word_q;
    bits_d    = bits_q;
    held_d    = held_q;
    lenb_d    = lenb_q;
    dist_d    = dist_q;
    wp_d      = wp_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    end_d     = end_q;
    acc_d     = acc_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    obyte_d   = obyte_q;
    ocount_d  = ocount_q;
    olast_d   = olast_q;
    oend_d    = oend_q;
    ram_we    = 1'b0;
    ram_waddr = wp_q;
    ram_wdata = in_byte_i;
    ram_re    = 1'b0;

    case (state_q)
      lzsd_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (phase_q)
            lzsd_pkg::PH_WORD_LO: begin
              held_d  = in_byte_i;
              phase_d = lzsd_pkg::PH_WORD_HI;
            end
            lzsd_pkg::PH_WORD_HI: begin
              word_d  = {in_byte_i, held_q};
              bits_d  = lzsd_pkg::WordBits;
              phase_d = resume_q;
            end
            lzsd_pkg::PH_LIT: begin
              // Store the literal and stage it as a one-byte result
              ram_we   = 1'b1;
              wp_d     = wp_q + AW'(1);
              acc_d[0] = in_byte_i;
              cnt_d    = lzsd_pkg::CntW'(1);
              phase_d  = lzsd_pkg::PH_BIT1;
            end
            lzsd_pkg::PH_SHORT_DIST: begin
              dist_d  = lzsd_pkg::ShortReach - {{(DW-8){1'b0}}, in_byte_i};
              rem_d   = lzsd_pkg::RemW'(lenb_q) + lzsd_pkg::RemW'(2);
              phase_d = lzsd_pkg::PH_BIT1;
            end
            lzsd_pkg::PH_LONG_LO: begin
              held_d  = in_byte_i;
              phase_d = lzsd_pkg::PH_LONG_HI;
            end
            lzsd_pkg::PH_LONG_HI: begin
              dist_d = lzsd_pkg::LongReach - {1'b0, in_byte_i[7:3], held_q};
              if (in_byte_i[2:0] != 3'd0) begin
                rem_d   = lzsd_pkg::RemW'(in_byte_i[2:0]) + lzsd_pkg::RemW'(2);
                phase_d = lzsd_pkg::PH_BIT1;
              end else begin
                phase_d = lzsd_pkg::PH_EXT_LEN;
              end
            end
            lzsd_pkg::PH_EXT_LEN: begin
              if (in_byte_i == 8'd0) begin
                // End mark: restart the parser, keep the window
                end_d    = 1'b1;
                cnt_d    = '0;
                word_d   = '0;
                bits_d   = '0;
                phase_d  = lzsd_pkg::PH_WORD_LO;
                resume_d = lzsd_pkg::PH_BIT1;
                held_d   = '0;
                lenb_d   = '0;
                dist_d   = '0;
              end else begin
                if (in_byte_i != 8'd1) begin
                  rem_d = lzsd_pkg::RemW'(in_byte_i) + lzsd_pkg::RemW'(1);
                end
                phase_d = lzsd_pkg::PH_BIT1;
              end
            end
            default: ;
          endcase
        end
      end
      lzsd_pkg::ST_ADV: begin
        phase_d  = fstep.phase;
        resume_d = fstep.resume;
        word_d   = fstep.word;
        bits_d   = fstep.bits_left;
        lenb_d   = fstep.length_bits;
      end
      lzsd_pkg::ST_RD: begin
        ram_re = 1'b1;
      end
      lzsd_pkg::ST_WR: begin
        // Write the copied byte back and pack it into the next lane
        ram_we                              = 1'b1;
        ram_wdata                           = ram_rdata;
        acc_d[cnt_q[lzsd_pkg::LaneW-1:0]]   = ram_rdata;
        cnt_d                               = cnt_q + lzsd_pkg::CntW'(1);
        wp_d                                = wp_q + AW'(1);
        rem_d                               = rem_q - lzsd_pkg::RemW'(1);
      end
      lzsd_pkg::ST_PUSH: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = acc_q;
          ocount_d = 3'(cnt_q);
          olast_d  = (rem_q == '0);
          oend_d   = end_q;
          for (int i = 0; i < NB; i++) begin
            acc_d[i] = 8'd0;
          end
          cnt_d = '0;
          end_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lzsd_pkg::ST_IDLE;
      phase_q  <= lzsd_pkg::PH_WORD_LO;
      resume_q <= lzsd_pkg::PH_BIT1;
      word_q   <= '0;
      bits_q   <= '0;
      held_q   <= '0;
      lenb_q   <= '0;
      dist_q   <= '0;
      wp_q     <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      end_q    <= 1'b0;
      ovalid_q <= 1'b0;
      ocount_q <= '0;
      olast_q  <= 1'b0;
      oend_q   <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        acc_q[i]   <= 8'd0;
        obyte_q[i] <= 8'd0;
      end
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      resume_q <= resume_d;
      word_q   <= word_d;
      bits_q   <= bits_d;
      held_q   <= held_d;
      lenb_q   <= lenb_d;
      dist_q   <= dist_d;
      wp_q     <= wp_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      end_q    <= end_d;
      ovalid_q <= ovalid_d;
      ocount_q <= ocount_d;
      olast_q  <= olast_d;
      oend_q   <= oend_d;
      acc_q    <= acc_d;
      obyte_q  <= obyte_d;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign out_byte0_o   = obyte_q[0];
  assign out_byte1_o   = obyte_q[1];
  assign out_byte2_o   = obyte_q[2];
  assign out_byte3_o   = obyte_q[3];
  assign byte_count_o  = ocount_q;
  assign last_of_run_o = olast_q;
  assign stream_end_o  = oend_q;

endmodule

// ===== bench/lzexe_decode_checker.sv =====
// ----------------------------------------------------------------------------
// lzexe_decode_checker
// Watches both streams of the decompressor, decodes every accepted input beat
// with its own copy of the parser and history, and compares each result beat
// field by field with the oldest predicted chunk.
// ----------------------------------------------------------------------------
module lzexe_decode_checker
  import lzsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte0_i,
  input  logic [7:0]  out_byte1_i,
  input  logic [7:0]  out_byte2_i,
  input  logic [7:0]  out_byte3_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_of_run_i,
  input  logic        stream_end_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ExtEnd     = 8'h00;
  localparam logic [7:0] ExtSegment = 8'h01;

  typedef struct packed {
    logic [3:0][7:0] lanes;
    logic [2:0]      count;
    logic            last;
    logic            stream_end;
  } lz_chunk_t;

  // Predicted parser and history
  logic [7:0]       window [WindowBytes];
  logic [AddrW-1:0] wr_pos;
  logic [15:0]      flag_word;
  logic [4:0]       bits_left;
  phase_e           phase;
  phase_e           resume;
  logic [7:0]       held_lo;
  logic [1:0]       len_bits;
  logic [DistW-1:0] copy_dist;

  lz_chunk_t  expected_chunks [$];
  logic [7:0] run_bytes [$];

  function automatic logic is_bit_phase(input phase_e ph);
    return ph == PH_BIT1 || ph == PH_BIT2 || ph == PH_LEN_A || ph == PH_LEN_B;
  endfunction

  task automatic restart_parser();
    flag_word = '0;
    bits_left = '0;
    phase     = PH_WORD_LO;
    resume    = PH_BIT1;
    held_lo   = '0;
    len_bits  = '0;
    copy_dist = '0;
  endtask

  // Consume flag bits until a phase needs an input byte
  task automatic use_flag_bits();
    logic   fbit;
    phase_e nxt;
    while (is_bit_phase(phase)) begin
      if (bits_left == 0) begin
        resume = phase;
        phase  = PH_WORD_LO;
      end else begin
        fbit      = flag_word[0];
        flag_word = flag_word >> 1;
        bits_left = bits_left - 1'b1;
        case (phase)
          PH_BIT1: nxt = fbit ? PH_LIT : PH_BIT2;
          PH_BIT2: nxt = fbit ? PH_LONG_LO : PH_LEN_A;
          PH_LEN_A: begin
            len_bits = {fbit, 1'b0};
            nxt      = PH_LEN_B;
          end
          default: begin
            len_bits = {len_bits[1], fbit};
            nxt      = PH_SHORT_DIST;
          end
        endcase
        if (bits_left == 0) begin
          resume = nxt;
          phase  = PH_WORD_LO;
        end else begin
          phase = nxt;
        end
      end
    end
  endtask

  // Split the collected run into chunks of up to four bytes
  task automatic queue_run();
    lz_chunk_t chunk;
    int        idx;
    int        cnt;
    idx = 0;
    while (idx < run_bytes.size()) begin
      chunk = '0;
      cnt   = run_bytes.size() - idx;
      if (cnt > BytesPerResult) cnt = BytesPerResult;
      for (int k = 0; k < cnt; k++) chunk.lanes[k] = run_bytes[idx + k];
      chunk.count = 3'(cnt);
      idx        += cnt;
      chunk.last  = (idx == run_bytes.size());
      expected_chunks.push_back(chunk);
    end
    run_bytes.delete();
  endtask

  // Copy from history, byte by byte so that overlaps repeat
  task automatic copy_history(input logic [DistW-1:0] span, input int len);
    logic [7:0] v;
    for (int i = 0; i < len; i++) begin
      v              = window[wr_pos - span[AddrW-1:0]];
      window[wr_pos] = v;
      wr_pos         = wr_pos + 1'b1;
      run_bytes.push_back(v);
    end
    queue_run();
  endtask

  // Advance the predicted parser by one compressed byte
  task automatic decode_beat(input logic [7:0] b);
    lz_chunk_t        end_chunk;
    logic [DistW-1:0] span;
    case (phase)
      PH_WORD_LO: begin
        held_lo = b;
        phase   = PH_WORD_HI;
      end
      PH_WORD_HI: begin
        flag_word = {b, held_lo};
        bits_left = WordBits;
        phase     = resume;
        use_flag_bits();
      end
      PH_LIT: begin
        window[wr_pos] = b;
        wr_pos         = wr_pos + 1'b1;
        run_bytes.push_back(b);
        queue_run();
        phase = PH_BIT1;
        use_flag_bits();
      end
      PH_SHORT_DIST: begin
        copy_history(ShortReach - DistW'(b), int'(len_bits) + 2);
        phase = PH_BIT1;
        use_flag_bits();
      end
      PH_LONG_LO: begin
        held_lo = b;
        phase   = PH_LONG_HI;
      end
      PH_LONG_HI: begin
        span = LongReach - DistW'({b[7:3], held_lo});
        if (b[2:0] != 3'd0) begin
          copy_history(span, int'(b[2:0]) + 2);
          phase = PH_BIT1;
          use_flag_bits();
        end else begin
          copy_dist = span;
          phase     = PH_EXT_LEN;
        end
      end
      PH_EXT_LEN: begin
        if (b == ExtEnd) begin
          end_chunk            = '0;
          end_chunk.last       = 1'b1;
          end_chunk.stream_end = 1'b1;
          expected_chunks.push_back(end_chunk);
          restart_parser();
        end else begin
          if (b != ExtSegment) copy_history(copy_dist, int'(b) + 1);
          phase = PH_BIT1;
          use_flag_bits();
        end
      end
      default: ;
    endcase
  endtask

  // Compare result beats, then predict from input beats
  always @(posedge clk_i or negedge rst_ni) begin
    lz_chunk_t got;
    lz_chunk_t want;
    if (!rst_ni) begin
      wr_pos = '0;
      restart_parser();
      expected_chunks.delete();
      run_bytes.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.lanes      = {out_byte3_i, out_byte2_i, out_byte1_i, out_byte0_i};
        got.count      = byte_count_i;
        got.last       = last_of_run_i;
        got.stream_end = stream_end_i;
        if (expected_chunks.size() == 0) begin
          $error("result beat with nothing expected: count %0d", got.count);
          fail_count_o++;
        end else begin
          want = expected_chunks.pop_front();
          for (int k = 0; k < BytesPerResult; k++) begin
            if (got.lanes[k] !== want.lanes[k]) begin
              $error("out_byte%0d: expected %02h, got %02h", k, want.lanes[k],
                     got.lanes[k]);
              fail_count_o++;
            end
          end
          if (got.count !== want.count) begin
            $error("byte_count: expected %0d, got %0d", want.count, got.count);
            fail_count_o++;
          end
          if (got.last !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, got.last);
            fail_count_o++;
          end
          if (got.stream_end !== want.stream_end) begin
            $error("stream_end: expected %0b, got %0b", want.stream_end,
                   got.stream_end);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_beat(in_byte_i);
      pending_o = expected_chunks.size();
    end
  end

endmodule

// ===== bench/lzexe_stream_decompressor_tb.sv =====
// ----------------------------------------------------------------------------
// lzexe_stream_decompressor_tb
// Encodes compressed streams (literals, short and long copies, extended
// lengths, segment markers, end marks) with valid history distances, feeds
// them in bursts against a stalling receiver and reports the checker verdict.
// ----------------------------------------------------------------------------
module lzexe_stream_decompressor_tb;

  import lzsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 100;
  localparam int RandomItems = 40;
  localparam int NoiseBytes  = 40;

  localparam logic FlagLiteral = 1'b1;
  localparam logic FlagCopy    = 1'b0;
  localparam logic FlagShort   = 1'b0;
  localparam logic FlagLong    = 1'b1;

  localparam logic [7:0] ExtEnd     = 8'h00;
  localparam logic [7:0] ExtSegment = 8'h01;

  localparam logic [1:0] RxFree   = 2'd0;
  localparam logic [1:0] RxRandom = 2'd1;
  localparam logic [1:0] RxPulse  = 2'd2;
  localparam logic [1:0] RxSparse = 2'd3;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] byte_count;
  logic       last_of_run;
  logic       stream_end;

  int unsigned fail_count;
  int unsigned pending;

  // Compressed stream under construction
  logic [7:0]  comp_bytes [$];
  int          word_slot;
  logic [15:0] word_acc;
  int          word_fill;
  int          hist_total;

  logic [1:0] rx_mode  = RxFree;
  logic [7:0] rx_count = 8'h00;

  lzexe_stream_decompressor dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_byte_i    (in_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte0_o  (out_byte0),
    .out_byte1_o  (out_byte1),
    .out_byte2_o  (out_byte2),
    .out_byte3_o  (out_byte3),
    .byte_count_o (byte_count),
    .last_of_run_o(last_of_run),
    .stream_end_o (stream_end)
  );

  lzexe_decode_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte0_i  (out_byte0),
    .out_byte1_i  (out_byte1),
    .out_byte2_i  (out_byte2),
    .out_byte3_i  (out_byte3),
    .byte_count_i (byte_count),
    .last_of_run_i(last_of_run),
    .stream_end_i (stream_end),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: pick a new stall pattern whenever the low six bits of rx_count are zero
  always @(posedge clk) begin
    rx_count <= rx_count + 1'b1;
    if (rx_count[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      RxFree:   out_ready <= 1'b1;
      RxRandom: out_ready <= ($urandom_range(0, 2) != 0);
      RxPulse:  out_ready <= (rx_count[1:0] == 2'b11);
      default:  out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Open a fresh flag word slot at the end of the stream
  task automatic open_word();
    word_slot = comp_bytes.size();
    comp_bytes.push_back(8'h00);
    comp_bytes.push_back(8'h00);
    word_acc  = '0;
    word_fill = 0;
  endtask

  task automatic close_word();
    comp_bytes[word_slot]     = word_acc[7:0];
    comp_bytes[word_slot + 1] = word_acc[15:8];
  endtask

  // The decoder fetches the next word right after the sixteenth bit
  task automatic put_flag(input logic fbit);
    word_acc[word_fill] = fbit;
    word_fill++;
    if (word_fill == 16) begin
      close_word();
      open_word();
    end
  endtask

  task automatic emit_literal(input logic [7:0] value);
    put_flag(FlagLiteral);
    comp_bytes.push_back(value);
    hist_total++;
  endtask

  task automatic emit_short(input int len, input int span);
    logic [1:0] lb;
    lb = 2'(len - 2);
    put_flag(FlagCopy);
    put_flag(FlagShort);
    put_flag(lb[1]);
    put_flag(lb[0]);
    comp_bytes.push_back(8'(256 - span));
    hist_total += len;
  endtask

  task automatic emit_long_code(input logic [AddrW-1:0] code, input logic [2:0] len3);
    put_flag(FlagCopy);
    put_flag(FlagLong);
    comp_bytes.push_back(code[7:0]);
    comp_bytes.push_back({code[12:8], len3});
  endtask

  task automatic emit_long(input int len, input int span);
    emit_long_code(AddrW'(WindowBytes - span), 3'(len - 2));
    hist_total += len;
  endtask

  task automatic emit_ext(input int len, input int span);
    emit_long_code(AddrW'(WindowBytes - span), 3'd0);
    comp_bytes.push_back(8'(len - 1));
    hist_total += len;
  endtask

  task automatic emit_segment();
    emit_long_code(AddrW'($urandom), 3'd0);
    comp_bytes.push_back(ExtSegment);
  endtask

  // End mark: the rest of the current word is dropped
  task automatic emit_end_mark();
    emit_long_code(AddrW'($urandom), 3'd0);
    comp_bytes.push_back(ExtEnd);
    close_word();
    open_word();
  endtask

  // Distance within the written history, biased to both ends
  function automatic int pick_dist(input int reach);
    int lim;
    lim = (reach < hist_total) ? reach : hist_total;
    case ($urandom_range(0, 7))
      0:       return 1;
      1:       return lim;
      default: return $urandom_range(1, lim);
    endcase
  endfunction

  // Drive bytes in bursts with random gaps, holding each until accepted
  task automatic send_range(input int first, input int stop);
    int burst;
    int gap;
    int idx;
    burst = 0;
    for (idx = first; idx < stop; idx++) begin
      if (burst == 0) begin
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_valid <= 1'b1;
      in_byte  <= comp_bytes[idx];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("lzexe_stream_decompressor verification failed");
    $finish;
  end

  initial begin
    int directed_end;
    int items;
    int stream_len;
    int sel;
    int len;
    hist_total = 0;
    open_word();

    // Directed stream: byte extremes, every code, overlap and reach limits
    emit_literal(8'h00);
    emit_literal(8'hff);
    emit_literal(8'h5a);
    emit_literal(8'ha5);
    emit_ext(256, 4);
    emit_short(2, 1);
    emit_short(3, 2);
    emit_short(4, 3);
    emit_short(5, 256);
    emit_long(3, 1);
    emit_long(9, hist_total);
    emit_long(5, 200);
    emit_ext(3, 1);
    emit_ext(100, 257);
    emit_segment();
    emit_literal(8'h3c);
    emit_end_mark();
    emit_end_mark();
    emit_literal(8'hc3);
    emit_end_mark();
    directed_end = word_slot;

    // Random streams of valid codes
    items = 0;
    while (items < RandomItems) begin
      stream_len = $urandom_range(1, 48);
      for (int j = 0; j < stream_len; j++) begin
        sel = $urandom_range(0, 99);
        if (hist_total == 0 || sel < 45) begin
          emit_literal(8'($urandom));
        end else if (sel < 65) begin
          emit_short($urandom_range(2, 5), pick_dist(256));
        end else if (sel < 80) begin
          emit_long($urandom_range(3, 9), pick_dist(WindowBytes));
        end else if (sel < 93) begin
          len = ($urandom_range(0, 11) == 0) ? $urandom_range(3, 256) : $urandom_range(3, 24);
          emit_ext(len, pick_dist(WindowBytes));
        end else begin
          emit_segment();
        end
        items++;
      end
      emit_end_mark();
      items++;
    end

    // Fill and wrap the window, then hit the full reach
    while (hist_total < WindowBytes + 512) emit_ext(256, pick_dist(WindowBytes));
    emit_long(9, WindowBytes);
    emit_short(5, 256);
    emit_ext(256, WindowBytes);
    emit_end_mark();

    // Drop the unused word slot; trail with noise once all history is written
    while (comp_bytes.size() > word_slot) void'(comp_bytes.pop_back());
    repeat (NoiseBytes) comp_bytes.push_back(8'($urandom));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_range(0, directed_end);
    // Hold off until every directed result is out
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    send_range(directed_end, comp_bytes.size());

    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("lzexe_stream_decompressor verification clean");
    end else begin
      $display("lzexe_stream_decompressor verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lzsd_pkg.sv
rtl/lzsd_ram.sv
rtl/lzsd_flag_unit.sv
rtl/lzexe_stream_decompressor.sv
bench/lzexe_decode_checker.sv
bench/lzexe_stream_decompressor_tb.sv
